/* hw/rtl/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// lpfd_pkg : shared types for the length-prefixed frame deframer
// Result word layout, result kinds and queue sizing.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  // result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TOO_BIG = 2'd2
  } kind_t;

  // one result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

  // queue fill status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] NULL_LENGTH = 32'hFFFF_FFFF;
  localparam logic [1:0]  HDR_LAST    = 2'd3;

endpackage

/* hw/rtl/lpfd_front.sv */
// ----------------------------------------------------------------------------
// lpfd_front : header parser and classifier
// Takes one stream byte per word, tracks header/payload/blocked phase and
// pushes at most one result word per byte into the queue.
// ----------------------------------------------------------------------------
module lpfd_front import lpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  qstat_t      q_stat,
  output logic        q_push,
  output res_t        q_wdata
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_BLOCKED = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rcv_r, rcv_nxt;
  logic [31:0] max_r;

  logic accept;
  logic res_vld;
  res_t res;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && res_vld;
  assign q_wdata   = res;

  // limit register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  // classify the current byte
  always_comb begin
    logic [31:0] shifted;
    logic [31:0] rcv_inc;
    logic        last;
    shifted     = {len_r[23:0], in_tdata};
    rcv_inc     = rcv_r + 32'd1;
    last        = (rcv_inc == len_r);
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    len_nxt     = len_r;
    rcv_nxt     = rcv_r;
    res_vld     = 1'b0;
    res.kind         = KIND_TOO_BIG;
    res.payload_byte = '0;
    res.last         = 1'b0;
    case (phase_r)
      PH_BLOCKED: begin
        res_vld = 1'b1;
      end
      PH_PAYLOAD: begin
        res_vld = 1'b1;
        if (max_r != '0 && len_r > max_r) begin
          // limit lowered under a running message
          phase_nxt = PH_BLOCKED;
        end else begin
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = in_tdata;
          res.last         = last;
          rcv_nxt          = rcv_inc;
          if (last) begin
            phase_nxt   = PH_HEADER;
            hdr_cnt_nxt = '0;
            len_nxt     = '0;
            rcv_nxt     = '0;
          end
        end
      end
      default: begin
        // header phase, also any stray phase code
        phase_nxt   = PH_HEADER;
        len_nxt     = shifted;
        hdr_cnt_nxt = hdr_cnt_r + 2'd1;
        if (hdr_cnt_r == HDR_LAST) begin
          rcv_nxt = '0;
          if (shifted == NULL_LENGTH) begin
            len_nxt = '0;
          end else if (max_r != '0 && shifted > max_r) begin
            phase_nxt = PH_BLOCKED;
            res_vld   = 1'b1;
          end else if (shifted == '0) begin
            res_vld  = 1'b1;
            res.kind = KIND_EMPTY;
            res.last = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      len_r     <= '0;
      rcv_r     <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      len_r     <= len_nxt;
      rcv_r     <= rcv_nxt;
    end
  end

endmodule

/* hw/rtl/lpfd_queue.sv */
// ----------------------------------------------------------------------------
// lpfd_queue : short result queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lpfd_queue import lpfd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  res_t   wdata,
  input  logic   pop,
  output res_t   rdata,
  output qstat_t stat
);

  res_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* hw/rtl/lpfd_back.sv */
// ----------------------------------------------------------------------------
// lpfd_back : output stage
// Pulls result words from the queue into the output register and holds
// them while the receiver stalls.
// ----------------------------------------------------------------------------
module lpfd_back import lpfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qstat_t     q_stat,
  input  res_t       q_rdata,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  logic vld_r;
  res_t res_r;

  // refill whenever the output register is free or being taken
  assign q_pop = !q_stat.empty && (!vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_rdata;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.payload_byte;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

/* hw/rtl/length_prefixed_frame_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer : 32-bit big-endian length-prefixed deframer
//
// Input stream (in_*): one raw byte per word on in_tdata. Each message starts
// with a four-byte big-endian length. Length all-ones is a null message and
// is dropped. Length zero gives one empty-message word. A length above the
// nonzero limit on cfg_wr_data (written with cfg_wr_en, zero = no limit)
// gives a too-big word, after which every byte gives a too-big word until
// reset. Otherwise each payload byte comes out with tlast on the final one.
// Output stream (out_*): tuser = kind (payload / empty / too big).
// Throughput: one byte per cycle while the queue is not full; the parser updates its phase, header shift
// register and byte counter once per accepted word.
// Path: the queue is written at the accepting edge; the output register that
// drives out_tvalid then loads the word once it is free or being taken.
// When the receiver stalls, results collect in a four-entry queue; in_tready
// drops only once it is full. Reset clears phase, counters, queue, output
// valid and the limit (to zero).
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer import lpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // max_message_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] stream_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [7:0] payload_byte
  output logic [1:0]  out_tuser,     // [1:0] kind
  output logic        out_tlast      // last_of_message
);

  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  res_t   q_wdata;
  res_t   q_rdata;

  lpfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  lpfd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  lpfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/lpfd_checker.sv */
// ----------------------------------------------------------------------------
// lpfd_checker : port-level checks for the deframer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module lpfd_checker import lpfd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic blocked_seen_r;

  // a delivered too-big word means the stream stays blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tuser == KIND_TOO_BIG) begin
      blocked_seen_r <= 1'b1;
    end
  end

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // non-payload words carry zero data, last only on empty message
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PAYLOAD |->
      out_tdata == 8'd0 && out_tlast == (out_tuser == KIND_EMPTY))
    else $error("bad fields on non-payload word");

  // once blocked, only too-big words follow
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && blocked_seen_r |-> out_tuser == KIND_TOO_BIG)
    else $error("word other than too-big after blocking");

  // no output word right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for length_prefixed_frame_deframer
// Drives a byte stream of length-prefixed messages and checks every result
// word against a cycle-free model of the deframer. A short table of directed
// words comes first. Random phases under several size limits follow, with
// random gaps and stalls on both sides and one long receiver stall. The run
// ends by forcing the block into its blocked state.
// ----------------------------------------------------------------------------
module tb;
  import lpfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned WORD_TARGET = 1300;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_BLOCKED = 2'd2
  } frame_phase_t;

  // one directed stimulus row; typed rows carry their own expected word
  typedef struct {
    logic [7:0] stream_byte;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] stream_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;    // [7:0] payload_byte
  logic [1:0]  out_tuser;    // [1:0] kind
  logic        out_tlast;    // last_of_message

  // deframer model state and its copy of the size limit
  frame_phase_t frame_phase;
  logic [1:0]   hdr_count;
  logic [31:0]  frame_len;
  logic [31:0]  rx_count;
  logic [31:0]  size_limit;

  res_t         pending_results[$];
  int unsigned  words_sent;
  int unsigned  results_seen;
  int unsigned  too_big_seen;
  int unsigned  mismatches;
  int unsigned  limit_writes;
  int unsigned  cycles;
  int unsigned  stall_left;
  bit           stall_done;
  bit           block_at_header;
  res_t         got_word;
  res_t         want_word;

  dir_row_t dir_rows [19] = '{
    // empty message
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 1'b1}},
    // null message, dropped silently
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    // two-byte message with extreme payload values
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 1'b0}},
    '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 1'b1}},
    // single-byte message
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hA5, 1'b0, '0}
  };

  length_prefixed_frame_deframer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit over_limit(input logic [31:0] len);
    return (size_limit != 32'd0) && (len > size_limit);
  endfunction

  // advance the model by one stream byte; returns 1 when a result word is due
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    r = '{KIND_PAYLOAD, 8'h00, 1'b0};
    case (frame_phase)
      PH_BLOCKED: begin
        r.kind = KIND_TOO_BIG;
        return 1'b1;
      end
      PH_PAYLOAD: begin
        // limit is rechecked on every payload byte
        if (over_limit(frame_len)) begin
          frame_phase = PH_BLOCKED;
          r.kind = KIND_TOO_BIG;
          return 1'b1;
        end
        rx_count = rx_count + 32'd1;
        r.payload_byte = b;
        r.last = (rx_count == frame_len);
        if (r.last) begin
          frame_phase = PH_HEADER;
          hdr_count = 2'd0;
          frame_len = 32'd0;
          rx_count = 32'd0;
        end
        return 1'b1;
      end
      default: begin
        frame_phase = PH_HEADER;
        frame_len = {frame_len[23:0], b};
        hdr_count = hdr_count + 2'd1;
        if (hdr_count != 2'd0) return 1'b0;
        rx_count = 32'd0;
        if (frame_len == NULL_LENGTH) begin
          frame_len = 32'd0;
          return 1'b0;
        end
        if (over_limit(frame_len)) begin
          frame_phase = PH_BLOCKED;
          r.kind = KIND_TOO_BIG;
          return 1'b1;
        end
        if (frame_len == 32'd0) begin
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
          return 1'b1;
        end
        frame_phase = PH_PAYLOAD;
        return 1'b0;
      end
    endcase
  endfunction

  // offer one byte with a random gap in front, record the expected word on accept
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    res_t r;
    bit   due;
    @(negedge clk);
    while (!(words_sent >= 500 && words_sent < 700) &&
           $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    due = deframe_byte(b, r);
    if (typed) pending_results.push_back(want);
    else if (due) pending_results.push_back(r);
    words_sent++;
  endtask

  task automatic send_rand_byte();
    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // four length bytes, most significant first
  task automatic send_header(input logic [31:0] len);
    for (int k = 3; k >= 0; k--) send_byte(len[8*k +: 8], 1'b0, '0);
  endtask

  // stop offering, let the block drain, then write the limit
  task automatic write_limit(input logic [31:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    size_limit = v;
    limit_writes++;
  endtask

  // well-formed messages under one limit; lengths never exceed it
  task automatic run_phase(input logic [31:0] lim, input int unsigned n_words);
    int unsigned start;
    int unsigned cap;
    int unsigned pick;
    logic [31:0] len;
    write_limit(lim);
    start = words_sent;
    cap = (lim == 32'd0 || lim > 32'd40) ? 40 : lim;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 8)       len = NULL_LENGTH;
      else if (pick < 18) len = 32'd0;
      else if (pick < 28) len = cap;
      else if (pick < 75) len = $urandom_range(1, (cap > 8) ? 8 : cap);
      else                len = $urandom_range(1, cap);
      send_header(len);
      if (len != NULL_LENGTH) repeat (len) send_rand_byte();
    end
  endtask

  // stimulus
  initial begin
    logic [31:0] lim;
    int unsigned len;
    int unsigned phase_no;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 32'd0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    frame_phase = PH_HEADER;
    hdr_count   = 2'd0;
    frame_len   = 32'd0;
    rx_count    = 32'd0;
    size_limit  = 32'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, limit at its reset value of zero
    foreach (dir_rows[i]) send_byte(dir_rows[i].stream_byte, dir_rows[i].typed,
                                    dir_rows[i].want);

    // random phases, cycling through no limit, the extremes and random limits
    phase_no = 0;
    while (words_sent < WORD_TARGET) begin
      case (phase_no % 5)
        0:       lim = 32'd0;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = $urandom_range(1, 40);
        3:       lim = $urandom;
        default: lim = 32'd1;
      endcase
      run_phase(lim, 200);
      phase_no++;
    end

    // drive the block into its blocked state, either at a header or by
    // lowering the limit in the middle of a payload
    block_at_header = $urandom_range(0, 1);
    if (block_at_header) begin
      lim = $urandom_range(1, 40);
      write_limit(lim);
      send_header($urandom_range(0, 1) ? lim + 32'd1 : 32'hFFFF_FFFE);
    end else begin
      write_limit(32'd0);
      len = $urandom_range(4, 30);
      send_header(len);
      repeat ($urandom_range(1, len - 1)) send_rand_byte();
      write_limit($urandom_range(1, len - 1));
    end
    repeat ($urandom_range(6, 12)) send_rand_byte();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb: %0d stream words in, %0d result words checked, %0d too-big words",
             words_sent, results_seen, too_big_seen);
    $display("tb: %0d limit writes, block entered %s", limit_writes,
             block_at_header ? "at a header" : "by a lowered limit mid-payload");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, a calm stretch, one long hold to fill the queue
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!stall_done && results_seen >= 250) begin
        stall_done = 1'b1;
        stall_left = 200;
        out_tready <= 1'b0;
      end else if (results_seen >= 400 && results_seen < 600) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic report(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb: %s at result %0d: want kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
               what, results_seen, want.kind, want.payload_byte, want.last,
               got.kind, got.payload_byte, got.last);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = '{kind_t'(out_tuser), out_tdata, out_tlast};
      if (pending_results.size() == 0) begin
        report("unexpected word", '0, got_word);
      end else begin
        want_word = pending_results.pop_front();
        if (got_word.kind !== want_word.kind ||
            got_word.payload_byte !== want_word.payload_byte ||
            got_word.last !== want_word.last)
          report("mismatch", want_word, got_word);
      end
      if (got_word.kind === KIND_TOO_BIG) too_big_seen++;
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout with %0d words still expected", pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule

/* files.f */
hw/rtl/lpfd_pkg.sv
hw/rtl/lpfd_front.sv
hw/rtl/lpfd_queue.sv
hw/rtl/lpfd_back.sv
hw/rtl/length_prefixed_frame_deframer.sv
hw/rtl/lpfd_checker.sv
bench/tb.sv
